// File: rtl/vtsp_pkg.sv
// shared types and constants for the visual target steering pid block
// no dependencies; imported by every other file of the block
package vtsp_pkg;

	// fixed-point constants
	localparam logic [16:0] HALF_Q16     = 17'd32768;
	localparam logic signed [11:0] FORWARD_BIAS = 12'sd50;
	// floor(p / 20) == (p * 52429) >> 20 for every 16-bit p, so the 5% window is exact
	localparam logic [15:0] WINDOW_RECIP = 16'd52429;
	localparam int unsigned WINDOW_SHIFT = 20;
	localparam logic [4:0]  JUMP_MAX     = 5'd31;
	localparam logic [2:0]  EMPTY_MAX    = 3'd7;
	localparam int unsigned SCALE_SHIFT  = 24;

	// command codes on the frame word
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	// register map, one word per register
	localparam int unsigned ADDR_W = 5;
	typedef enum logic [2:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_TURN_SCALE  = 3'd3,
		REG_MIN_SPEED   = 3'd4,
		REG_MAX_SPEED   = 3'd5,
		REG_JUMP_LIMIT  = 3'd6,
		REG_EMPTY_LIMIT = 3'd7
	} reg_idx_t;

	// end cause codes on the result word
	typedef enum logic [1:0] {
		CAUSE_RUNNING = 2'd0,
		CAUSE_JUMPED  = 2'd1,
		CAUSE_LOST    = 2'd2
	} cause_t;

	// what kind of result the current frame produces
	typedef enum logic [1:0] {
		KIND_ZERO = 2'd0,
		KIND_JUMP = 2'd1,
		KIND_RUN  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [9:0]  turn_scale;
		logic [9:0]  min_speed;
		logic [9:0]  max_speed;
		logic [3:0]  jump_limit;
		logic [2:0]  empty_limit;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic window;
		logic check;
		logic update;
		logic mult;
		logic sum;
		logic absval;
		logic scale;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run;
		logic out_busy;
	} stat_t;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_WIN   = 9'b000000010,
		ST_CHECK = 9'b000000100,
		ST_UPD   = 9'b000001000,
		ST_MUL   = 9'b000010000,
		ST_SUM   = 9'b000100000,
		ST_ABS   = 9'b001000000,
		ST_SCALE = 9'b010000000,
		ST_EMIT  = 9'b100000000
	} state_t;

endpackage

// File: rtl/vtsp_regs.sv
// configuration register file behind an apb-style port
// depends on vtsp_pkg for the register map and the cfg_t struct
module vtsp_regs import vtsp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p      <= 16'd256;
			cfg_q.gain_i      <= 16'd0;
			cfg_q.gain_d      <= 16'd0;
			cfg_q.turn_scale  <= 10'd100;
			cfg_q.min_speed   <= 10'd10;
			cfg_q.max_speed   <= 10'd100;
			cfg_q.jump_limit  <= 4'd10;
			cfg_q.empty_limit <= 3'd5;
		end else if (wr_en) begin
			case (idx)
				REG_GAIN_P:      cfg_q.gain_p      <= pwdata[15:0];
				REG_GAIN_I:      cfg_q.gain_i      <= pwdata[15:0];
				REG_GAIN_D:      cfg_q.gain_d      <= pwdata[15:0];
				REG_TURN_SCALE:  cfg_q.turn_scale  <= pwdata[9:0];
				REG_MIN_SPEED:   cfg_q.min_speed   <= pwdata[9:0];
				REG_MAX_SPEED:   cfg_q.max_speed   <= pwdata[9:0];
				REG_JUMP_LIMIT:  cfg_q.jump_limit  <= pwdata[3:0];
				REG_EMPTY_LIMIT: cfg_q.empty_limit <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = 32'd0;
		case (idx)
			REG_GAIN_P:      prdata = {16'd0, cfg_q.gain_p};
			REG_GAIN_I:      prdata = {16'd0, cfg_q.gain_i};
			REG_GAIN_D:      prdata = {16'd0, cfg_q.gain_d};
			REG_TURN_SCALE:  prdata = {22'd0, cfg_q.turn_scale};
			REG_MIN_SPEED:   prdata = {22'd0, cfg_q.min_speed};
			REG_MAX_SPEED:   prdata = {22'd0, cfg_q.max_speed};
			REG_JUMP_LIMIT:  prdata = {28'd0, cfg_q.jump_limit};
			REG_EMPTY_LIMIT: prdata = {29'd0, cfg_q.empty_limit};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/vtsp_ctrl.sv
// sequencing state machine for one frame at a time
// depends on vtsp_pkg for state_t, cmd_t and stat_t
module vtsp_ctrl import vtsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  frame_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	assign in_ready = (state_q == ST_IDLE);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (frame_valid) state_nxt = ST_WIN;
			ST_WIN:   state_nxt = ST_CHECK;
			ST_CHECK: state_nxt = ST_UPD;
			ST_UPD:   state_nxt = stat.run ? ST_MUL : ST_EMIT;
			ST_MUL:   state_nxt = ST_SUM;
			ST_SUM:   state_nxt = ST_ABS;
			ST_ABS:   state_nxt = ST_SCALE;
			ST_SCALE: state_nxt = ST_EMIT;
			ST_EMIT:  if (!stat.out_busy) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// datapath commands
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) & frame_valid;
		cmd.window = (state_q == ST_WIN);
		cmd.check  = (state_q == ST_CHECK);
		cmd.update = (state_q == ST_UPD);
		cmd.mult   = (state_q == ST_MUL);
		cmd.sum    = (state_q == ST_SUM);
		cmd.absval = (state_q == ST_ABS);
		cmd.scale  = (state_q == ST_SCALE);
		cmd.emit   = (state_q == ST_EMIT) & ~stat.out_busy;
	end

endmodule

// File: rtl/vtsp_dp.sv
// run state, pid arithmetic, clamp and output register
// depends on vtsp_pkg for constants, cfg_t, cmd_t and stat_t
module vtsp_dp import vtsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic               command,
	input  logic               target_seen,
	input  logic [15:0]        target_x,
	input  logic [15:0]        target_y,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [10:0] left_speed,
	output logic signed [10:0] right_speed,
	output logic               finished,
	output logic [1:0]         end_cause
);

	// latched word
	logic        cmd_q;
	logic        seen_q;
	logic [15:0] x_q;
	logic [15:0] y_q;

	// run state
	logic               stopped_q;
	logic               have_prev_q;
	logic               have_prior_q;
	logic [4:0]         jump_cnt_q;
	logic [2:0]         empty_cnt_q;
	logic signed [31:0] error_sum_q;
	logic signed [16:0] last_err_q;
	logic signed [17:0] slope_q;
	logic [15:0]        prior_x_q;
	logic [15:0]        prior_y_q;
	kind_t              kind_q;

	// arithmetic registers
	logic [11:0]        dx_q;
	logic [11:0]        dy_q;
	logic signed [32:0] prod_p_q;
	logic signed [47:0] prod_i_q;
	logic signed [33:0] prod_d_q;
	logic signed [49:0] pid_q;
	logic               neg_q;
	logic [49:0]        mag_abs_q;
	logic [35:0]        mag_q;

	// output register
	logic               result_valid_q;
	logic signed [10:0] left_q;
	logic signed [10:0] right_q;
	logic               finished_q;
	cause_t             cause_q;

	logic [31:0]        win_px;
	logic [31:0]        win_py;
	logic               close;
	logic [4:0]         jump_nxt;
	logic signed [16:0] err;
	logic signed [32:0] sum_ext;
	logic signed [31:0] sum_sat;
	logic signed [49:0] pid_nxt;
	logic [49:0]        abs_nxt;
	logic [59:0]        scaled;
	logic [9:0]         clamped;
	logic signed [11:0] turn;
	logic signed [11:0] left_full;
	logic signed [11:0] right_full;
	logic               lost;

	function automatic logic in_window(input logic [15:0] prior, input logic [15:0] now,
			input logic [11:0] d);
		logic [16:0] lo_side;
		logic [16:0] hi_side;
		lo_side = {1'b0, now} + {5'd0, d};
		hi_side = {1'b0, prior} + {5'd0, d};
		return (lo_side >= {1'b0, prior}) && ({1'b0, now} <= hi_side);
	endfunction

	// window half-widths, prior / 20
	assign win_px = prior_x_q * WINDOW_RECIP;
	assign win_py = prior_y_q * WINDOW_RECIP;

	// location check
	assign close    = in_window(prior_x_q, x_q, dx_q) && in_window(prior_y_q, y_q, dy_q);
	assign jump_nxt = !have_prior_q ? jump_cnt_q :
		close ? 5'd0 : (jump_cnt_q < JUMP_MAX) ? jump_cnt_q + 5'd1 : jump_cnt_q;

	// error, saturating integral
	assign err     = $signed({1'b0, x_q} - HALF_Q16);
	assign sum_ext = 33'(error_sum_q) + 33'(err);
	assign sum_sat = (sum_ext[32] != sum_ext[31]) ?
		(sum_ext[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_ext[31:0];

	// pid sum, magnitude and scaling
	assign pid_nxt = 50'(prod_p_q) + 50'(prod_i_q) + 50'(prod_d_q);
	assign abs_nxt = pid_q[49] ? 50'(-pid_q) : 50'(pid_q);
	assign scaled  = 60'(mag_abs_q) * 60'(cfg.turn_scale);

	// clamp, then wheel speeds around the forward bias
	always_comb begin
		if (mag_q < {26'd0, cfg.min_speed}) begin
			clamped = cfg.min_speed;
		end else if (mag_q > {26'd0, cfg.max_speed}) begin
			clamped = cfg.max_speed;
		end else begin
			clamped = mag_q[9:0];
		end
	end
	assign turn       = neg_q ? -$signed({2'b00, clamped}) : $signed({2'b00, clamped});
	assign left_full  = FORWARD_BIAS + turn;
	assign right_full = FORWARD_BIAS - turn;
	assign lost       = !(empty_cnt_q < cfg.empty_limit);

	// input latch and arithmetic pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			seen_q <= target_seen;
			x_q    <= target_x;
			y_q    <= target_y;
		end
		if (cmd.window) begin
			dx_q <= win_px[31:WINDOW_SHIFT];
			dy_q <= win_py[31:WINDOW_SHIFT];
		end
		if (cmd.mult) begin
			prod_p_q <= $signed(cfg.gain_p) * last_err_q;
			prod_i_q <= $signed(cfg.gain_i) * error_sum_q;
			prod_d_q <= $signed(cfg.gain_d) * slope_q;
		end
		if (cmd.sum) begin
			pid_q <= pid_nxt;
		end
		if (cmd.absval) begin
			neg_q     <= pid_q[49];
			mag_abs_q <= abs_nxt;
		end
		if (cmd.scale) begin
			mag_q <= scaled[59:SCALE_SHIFT];
		end
	end

	// run state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q    <= 1'b1;
			have_prev_q  <= 1'b0;
			have_prior_q <= 1'b0;
			jump_cnt_q   <= 5'd0;
			empty_cnt_q  <= 3'd0;
			kind_q       <= KIND_ZERO;
		end else begin
			if (cmd.check) begin
				if (cmd_q == CMD_START) begin
					stopped_q    <= 1'b0;
					have_prev_q  <= 1'b0;
					have_prior_q <= 1'b0;
					jump_cnt_q   <= 5'd0;
					empty_cnt_q  <= 3'd0;
					kind_q       <= KIND_ZERO;
				end else if (stopped_q) begin
					kind_q <= KIND_ZERO;
				end else if (seen_q) begin
					jump_cnt_q <= jump_nxt;
					if (jump_nxt > {1'b0, cfg.jump_limit}) begin
						stopped_q <= 1'b1;
						kind_q    <= KIND_JUMP;
					end else begin
						kind_q <= KIND_RUN;
					end
				end else begin
					kind_q <= KIND_RUN;
				end
			end
			if (cmd.update && kind_q == KIND_RUN) begin
				have_prev_q <= 1'b1;
				if (seen_q) begin
					empty_cnt_q  <= 3'd0;
					have_prior_q <= 1'b1;
				end else if (empty_cnt_q < EMPTY_MAX) begin
					empty_cnt_q <= empty_cnt_q + 3'd1;
				end
			end
			if (cmd.emit && kind_q == KIND_RUN && lost) begin
				stopped_q <= 1'b1;
			end
		end
	end

	// controller terms and prior position
	always_ff @(posedge clk) begin
		if (cmd.check && cmd_q == CMD_START) begin
			error_sum_q <= 32'sd0;
			last_err_q  <= 17'sd0;
			slope_q     <= 18'sd0;
			prior_x_q   <= 16'd0;
			prior_y_q   <= 16'd0;
		end else if (cmd.update && kind_q == KIND_RUN && seen_q) begin
			error_sum_q <= sum_sat;
			if (have_prev_q) begin
				slope_q <= 18'(err) - 18'(last_err_q);
			end
			last_err_q <= err;
			prior_x_q  <= x_q;
			prior_y_q  <= y_q;
		end
	end

	// output word handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			left_q     <= 11'sd0;
			right_q    <= 11'sd0;
			finished_q <= 1'b0;
			cause_q    <= CAUSE_RUNNING;
			case (kind_q)
				KIND_JUMP: begin
					finished_q <= 1'b1;
					cause_q    <= CAUSE_JUMPED;
				end
				KIND_RUN: begin
					if (lost) begin
						finished_q <= 1'b1;
						cause_q    <= CAUSE_LOST;
					end else begin
						left_q  <= left_full[10:0];
						right_q <= right_full[10:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign stat.run      = (kind_q == KIND_RUN);
	assign stat.out_busy = result_valid_q & ~result_ready;

	assign result_valid = result_valid_q;
	assign left_speed   = left_q;
	assign right_speed  = right_q;
	assign finished     = finished_q;
	assign end_cause    = cause_q;

endmodule

// File: rtl/visual_target_steering_pid.sv
// a running frame goes through window, check, update, the pid steps and emit; a start command,
// a stopped frame or a jump end skips the pid steps; emit waits while the last word is not taken
// the frame sequencer handles one word at a time; the pid terms go mult, sum, abs, scale
// a finished word waits in the output register while the next word is taken in
// reset: registers return to defaults, run state cleared, the block waits stopped for a start
module visual_target_steering_pid import vtsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               frame_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic               target_seen,
	input  logic [15:0]        target_x,
	input  logic [15:0]        target_y,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [10:0] left_speed,
	output logic signed [10:0] right_speed,
	output logic               finished,
	output logic [1:0]         end_cause
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// configuration registers
	vtsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	vtsp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.in_ready    (in_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// datapath
	vtsp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.command      (command),
		.target_seen  (target_seen),
		.target_x     (target_x),
		.target_y     (target_y),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.left_speed   (left_speed),
		.right_speed  (right_speed),
		.finished     (finished),
		.end_cause    (end_cause)
	);

endmodule

// File: test/visual_target_steering_pid_check.sv
// checker for the visual target steering pid block: follows register writes, predicts
// every result word from the accepted frame words and compares it with what the block returns
// depends on vtsp_pkg for the register map, the end cause codes and the fixed-point constants
module visual_target_steering_pid_check import vtsp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	input  logic               frame_valid,
	input  logic               in_ready,
	input  logic               command,
	input  logic               target_seen,
	input  logic [15:0]        target_x,
	input  logic [15:0]        target_y,
	input  logic               result_valid,
	input  logic               result_ready,
	input  logic signed [10:0] left_speed,
	input  logic signed [10:0] right_speed,
	input  logic               finished,
	input  logic [1:0]         end_cause,
	output int unsigned        outstanding,
	output int unsigned        failures,
	output int unsigned        jump_ends,
	output int unsigned        lost_ends
);

	localparam int unsigned WINDOW_PCT = 5;
	localparam longint SUM_TOP    = 64'sh7fffffff;
	localparam longint SUM_BOTTOM = -64'sh80000000;
	localparam int unsigned REPORT_CAP = 100;

	typedef struct packed {
		logic signed [10:0] left;
		logic signed [10:0] right;
		logic               finished;
		cause_t             cause;
	} steer_word_t;

	// register copies
	logic signed [15:0] gain_p, gain_i, gain_d;
	logic [9:0]         turn_scale, min_speed, max_speed;
	logic [3:0]         jump_limit;
	logic [2:0]         empty_limit;

	// controller and tracking state
	logic signed [31:0] error_sum;
	logic signed [16:0] last_error;
	logic signed [17:0] slope;
	logic               have_previous;
	logic [15:0]        prior_x, prior_y;
	logic               have_prior_position;
	logic [4:0]         jump_count;
	logic [2:0]         empty_count;
	logic               stopped;

	steer_word_t due_words[$];
	steer_word_t got, want;
	int unsigned fail_count, jumped_count, lost_count;

	function automatic void clear_run();
		error_sum = '0;
		last_error = '0;
		slope = '0;
		have_previous = 1'b0;
		prior_x = '0;
		prior_y = '0;
		have_prior_position = 1'b0;
		jump_count = '0;
		empty_count = '0;
	endfunction

	// close when within prior +- floor(5% of prior)
	function automatic logic in_window(logic [15:0] prior, logic [15:0] now);
		int unsigned reach;
		reach = 32'(prior) * WINDOW_PCT / 100;
		return (32'(now) + reach >= 32'(prior)) && (32'(now) <= 32'(prior) + reach);
	endfunction

	// one frame or start word in, one wheel word out; updates the run state
	function automatic steer_word_t steer_frame(logic cmd, logic seen, logic [15:0] x,
			logic [15:0] y);
		steer_word_t word;
		int e;
		int turn;
		longint acc, pid;
		longint unsigned mag;
		word.left = '0;
		word.right = '0;
		word.finished = 1'b0;
		word.cause = CAUSE_RUNNING;
		if (cmd == CMD_START) begin
			clear_run();
			stopped = 1'b0;
			return word;
		end
		if (stopped)
			return word;

		if (seen) begin
			// position tracking, then the jump end before any controller update
			if (have_prior_position) begin
				if (in_window(prior_x, x) && in_window(prior_y, y))
					jump_count = '0;
				else if (jump_count < JUMP_MAX)
					jump_count++;
			end
			if (jump_count > jump_limit) begin
				stopped = 1'b1;
				jumped_count++;
				word.finished = 1'b1;
				word.cause = CAUSE_JUMPED;
				return word;
			end
			e = int'(x) - int'(HALF_Q16);
			acc = longint'(error_sum) + longint'(e);
			if (acc > SUM_TOP)
				acc = SUM_TOP;
			else if (acc < SUM_BOTTOM)
				acc = SUM_BOTTOM;
			error_sum = 32'(acc);
			if (have_previous)
				slope = 18'(e - int'(last_error));
			last_error = 17'(e);
			empty_count = '0;
			prior_x = x;
			prior_y = y;
			have_prior_position = 1'b1;
		end else if (empty_count < EMPTY_MAX) begin
			empty_count++;
		end

		// pid sum in Q.24, scaled and truncated on the magnitude, then clamped
		pid = longint'(gain_p) * longint'(last_error) + longint'(gain_i) * longint'(error_sum)
			+ longint'(gain_d) * longint'(slope);
		mag = (pid < 0) ? -pid : pid;
		mag = (mag * turn_scale) >> SCALE_SHIFT;
		if (mag < min_speed)
			mag = min_speed;
		else if (mag > max_speed)
			mag = max_speed;
		turn = (pid < 0) ? -int'(mag) : int'(mag);
		have_previous = 1'b1;

		if (!(empty_count < empty_limit)) begin
			stopped = 1'b1;
			lost_count++;
			word.finished = 1'b1;
			word.cause = CAUSE_LOST;
			return word;
		end
		word.left = 11'(int'(FORWARD_BIAS) + turn);
		word.right = 11'(int'(FORWARD_BIAS) - turn);
		return word;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p = 16'sd256;
			gain_i = '0;
			gain_d = '0;
			turn_scale = 10'd100;
			min_speed = 10'd10;
			max_speed = 10'd100;
			jump_limit = 4'd10;
			empty_limit = 3'd5;
			clear_run();
			stopped = 1'b1;
			due_words.delete();
			fail_count = 0;
			jumped_count = 0;
			lost_count = 0;
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_GAIN_P:      gain_p = pwdata[15:0];
					REG_GAIN_I:      gain_i = pwdata[15:0];
					REG_GAIN_D:      gain_d = pwdata[15:0];
					REG_TURN_SCALE:  turn_scale = pwdata[9:0];
					REG_MIN_SPEED:   min_speed = pwdata[9:0];
					REG_MAX_SPEED:   max_speed = pwdata[9:0];
					REG_JUMP_LIMIT:  jump_limit = pwdata[3:0];
					REG_EMPTY_LIMIT: empty_limit = pwdata[2:0];
					default: ;
				endcase
			end

			// returned word against the oldest prediction
			if (result_valid && result_ready) begin
				got.left = left_speed;
				got.right = right_speed;
				got.finished = finished;
				got.cause = cause_t'(end_cause);
				if (due_words.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_CAP)
						$display("%0t: word with nothing predicted: left %0d right %0d fin %0b cause %0d",
							$time, got.left, got.right, got.finished, got.cause);
				end else begin
					want = due_words.pop_front();
					if (got.left != want.left || got.right != want.right
							|| got.finished != want.finished || got.cause != want.cause) begin
						fail_count++;
						if (fail_count <= REPORT_CAP)
							$display("%0t: expected left %0d right %0d fin %0b cause %0d, got left %0d right %0d fin %0b cause %0d",
								$time, want.left, want.right, want.finished, want.cause,
								got.left, got.right, got.finished, got.cause);
					end
				end
			end

			// accepted word into the predictor
			if (frame_valid && in_ready)
				due_words.push_back(steer_frame(command, target_seen, target_x, target_y));
		end
		outstanding <= due_words.size();
		failures <= fail_count;
		jump_ends <= jumped_count;
		lost_ends <= lost_count;
	end

endmodule

// File: test/visual_target_steering_pid_test.sv
// top of the visual target steering pid testbench: clock, reset, register setup, frame
// and start words, random stalls on the result side and the verdict
// depends on vtsp_pkg, the block and visual_target_steering_pid_check
module visual_target_steering_pid_test import vtsp_pkg::*;;

	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_WORDS = 100;

	typedef enum {STYLE_STEADY, STYLE_JUMPY, STYLE_LOSSY, STYLE_NOISY} run_style_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               frame_valid = 1'b0;
	logic               in_ready;
	logic               command = CMD_FRAME;
	logic               target_seen = 1'b0;
	logic [15:0]        target_x = '0;
	logic [15:0]        target_y = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [10:0] left_speed;
	logic signed [10:0] right_speed;
	logic               finished;
	logic [1:0]         end_cause;

	int unsigned outstanding, failures, jump_ends, lost_ends;
	logic        calm = 1'b0;
	int unsigned holds_wanted = 0;
	int unsigned starts_sent = 0;
	int unsigned frames_sent = 0;

	visual_target_steering_pid u_top (.*);

	visual_target_steering_pid_check u_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#(12 * 600000);
		$display("TB_ERROR");
		$finish;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_span();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (calm || pick < 45)
			return 0;
		if (pick < 85)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] any_coord();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	// small move that stays inside the 5% window
	function automatic logic [15:0] nudge(logic [15:0] at);
		int unsigned step;
		step = $urandom_range(0, 32'(at) / 25);
		if ($urandom_range(0, 1))
			return (32'(at) + step > 32'hffff) ? 16'hffff : 16'(32'(at) + step);
		return 16'(32'(at) - step);
	endfunction

	task automatic send_word(input logic cmd, input logic seen, input logic [15:0] x,
			input logic [15:0] y);
		int unsigned gap;
		gap = idle_span();
		if (gap != 0) begin
			frame_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_valid <= 1'b1;
		command <= cmd;
		target_seen <= seen;
		target_x <= x;
		target_y <= y;
		do @(posedge clk); while (!in_ready);
		if (cmd == CMD_START)
			starts_sent++;
		else
			frames_sent++;
	endtask

	// wait for every predicted word, then let the pipeline settle
	task automatic drain_results();
		frame_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stalls, plus a long hold-off whenever one is requested
	initial begin : result_side
		int unsigned holds_done;
		int unsigned span;
		holds_done = 0;
		@(posedge clk);
		forever begin
			if (holds_wanted > holds_done) begin
				holds_done++;
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			span = idle_span();
			if (span != 0) begin
				result_ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned phase, sent, run_len, k, i, pick, far_pct, empty_pct;
		run_style_t style;
		logic [15:0] gp, gi, gd, cur_x, cur_y;
		logic [9:0]  ts, lo, hi;
		logic [3:0]  jl;
		logic [2:0]  el;
		logic        cmd, seen;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, default registers: frame before any start, centered target,
		// corner positions, a lost end, a frame while stopped, then a jump end
		send_word(CMD_FRAME, 1'b1, 16'hffff, 16'h0000);
		send_word(CMD_START, 1'b1, 16'h1234, 16'h5678);
		send_word(CMD_FRAME, 1'b1, 16'h8000, 16'h8000);
		send_word(CMD_FRAME, 1'b1, 16'h8000, 16'h8000);
		send_word(CMD_FRAME, 1'b1, 16'hffff, 16'hffff);
		send_word(CMD_FRAME, 1'b1, 16'h0000, 16'h0000);
		repeat (5) send_word(CMD_FRAME, 1'b0, 16'h0000, 16'h0000);
		send_word(CMD_FRAME, 1'b1, 16'h8000, 16'h8000);
		send_word(CMD_START, 1'b0, 16'h0000, 16'h0000);
		for (i = 0; i < 12; i++)
			send_word(CMD_FRAME, 1'b1, i[0] ? 16'hffff : 16'h0000, i[0] ? 16'h0000 : 16'hffff);
		drain_results();

		for (phase = 0; phase < PHASES; phase++) begin
			// register setting: both extremes first, then random ones
			case (phase)
				0: begin
					gp = 16'h7fff; gi = 16'h7fff; gd = 16'h7fff;
					ts = 10'd1023; lo = 10'd0; hi = 10'd600; jl = 4'd15; el = 3'd7;
				end
				1: begin
					gp = 16'h8000; gi = 16'h8000; gd = 16'h8000;
					ts = 10'd0; lo = 10'd600; hi = 10'd0; jl = 4'd0; el = 3'd1;
				end
				default: begin
					gp = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023) - 512) : 16'($urandom);
					gi = $urandom_range(0, 1) ? 16'($urandom_range(0, 63) - 32) : 16'($urandom);
					gd = $urandom_range(0, 1) ? 16'($urandom_range(0, 1023) - 512) : 16'($urandom);
					ts = 10'($urandom_range(0, 1023));
					lo = 10'($urandom_range(0, 600));
					hi = 10'($urandom_range(0, 600));
					jl = 4'($urandom_range(0, 15));
					el = 3'($urandom_range(1, 7));
				end
			endcase
			write_reg(REG_GAIN_P, {16'h0, gp});
			write_reg(REG_GAIN_I, {16'h0, gi});
			write_reg(REG_GAIN_D, {16'h0, gd});
			write_reg(REG_TURN_SCALE, {22'h0, ts});
			write_reg(REG_MIN_SPEED, {22'h0, lo});
			write_reg(REG_MAX_SPEED, {22'h0, hi});
			write_reg(REG_JUMP_LIMIT, {28'h0, jl});
			write_reg(REG_EMPTY_LIMIT, {29'h0, el});

			// some phases run without any idling; one holds the result side off
			calm <= (phase % 3 == 2);
			if (phase == 3)
				holds_wanted <= holds_wanted + 1;

			sent = 0;
			while (sent < PHASE_WORDS) begin
				// one run: a start word, then frames in one style (the noisy style mixes in start words)
				style = run_style_t'($urandom_range(0, 3));
				run_len = $urandom_range(4, 40);
				case (style)
					STYLE_STEADY: begin far_pct = 4;  empty_pct = 8;  end
					STYLE_JUMPY:  begin far_pct = 60; empty_pct = 5;  end
					STYLE_LOSSY:  begin far_pct = 5;  empty_pct = 45; end
					default:      begin far_pct = 0;  empty_pct = 0;  end
				endcase
				send_word(CMD_START, 1'($urandom_range(0, 1)), any_coord(), any_coord());
				sent++;
				cur_x = any_coord();
				cur_y = any_coord();
				for (k = 0; k < run_len && sent < PHASE_WORDS; k++) begin
					pick = $urandom_range(0, 99);
					cmd = CMD_FRAME;
					seen = 1'b1;
					if (style == STYLE_NOISY) begin
						cmd = (pick < 8) ? CMD_START : CMD_FRAME;
						seen = 1'($urandom_range(0, 1));
						cur_x = any_coord();
						cur_y = any_coord();
					end else if (pick < empty_pct) begin
						seen = 1'b0;
						send_word(cmd, seen, any_coord(), any_coord());
						sent++;
						continue;
					end else if (pick < empty_pct + far_pct) begin
						cur_x = any_coord();
						cur_y = any_coord();
					end else begin
						cur_x = nudge(cur_x);
						cur_y = nudge(cur_y);
					end
					send_word(cmd, seen, cur_x, cur_y);
					sent++;
				end
			end
			drain_results();
		end

		$display("sent %0d frame words and %0d start words over %0d register settings",
			frames_sent, starts_sent, PHASES + 1);
		$display("runs ended by a jumping target: %0d, by a lost target: %0d",
			jump_ends, lost_ends);
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
